// ===== hw/rtl/ptt_pkg.sv =====
// Shared types, widths and codes for the periodic task timer table.
package ptt_pkg;

    // Table geometry: slot numbers travel in four bits, so at most 16 slots.
    localparam int NUM_SLOTS   = 16;
    localparam int TABLE_SLOTS = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int RUN_W    = 4;
    localparam int PERIOD_W = 20;
    localparam int NOW_W    = 32;
    localparam int DUE_W    = 40;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W   = CFG_W + PERIOD_W;

    // Configuration register indexes and reset value.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CATCH_UP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESYNC       = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_RESET_VALUE  = 4'd10;

    // Input kind codes.
    localparam logic [KIND_W-1:0] KIND_SETUP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUMP   = 2'd2;

    // Command codes after classification.
    typedef logic [1:0] op_t;
    localparam op_t OP_SETUP  = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_PUMP   = 2'd2;
    localparam op_t OP_NOP    = 2'd3;

    // Command queue depth.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // One classified command.
    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   idx;
        logic [PERIOD_W-1:0] period;
        logic [NOW_W-1:0]    now;
    } cmd_t;

    // Configuration seen by the execution side.
    typedef struct packed {
        logic [CFG_W-1:0] max_catch_up;
        logic [CFG_W-1:0] resync_periods;
    } cfg_t;

endpackage

// ===== hw/rtl/periodic_task_timer_table_core.sv =====
// Top level of the periodic task timer table: configuration and front/back hookup.
//
// Usage: an item (kind, slot_index, period_ticks, now_ticks) transfers at a
// rising edge where start is high and busy is low. busy rises only when the
// two-entry command queue is full. Kind 0 claims the lowest free slot, kind 1
// frees a slot, kind 2 pumps all active slots at now_ticks, kind 3 does nothing.
// Every item produces one or more results; each result is shown for exactly
// one cycle with done high and the last result of an item has last high.
// The receiver cannot stall, so done is never held.
// Setup, remove and idle items have their result registered as the back end
// takes them from the queue. A pump walks the slots in order; an active slot
// runs catch-up (up to 15 runs, one run per cycle on a shared adder), then a
// multiply and a resync check. Configuration writes use cfg_valid/cfg_ready
// (always ready): index 0 is max_catch_up, index 1 is resync_periods, both
// reset to 10. The user must write them only while the block is idle; the
// block does not enforce this. Reset empties the queue and frees all slots.
module periodic_task_timer_table_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ptt_pkg::KIND_W-1:0]       kind,
    input  logic [ptt_pkg::SLOT_W-1:0]       slot_index,
    input  logic [ptt_pkg::PERIOD_W-1:0]     period_ticks,
    input  logic [ptt_pkg::NOW_W-1:0]        now_ticks,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]        cfg_data,
    output logic                             done,
    output logic [ptt_pkg::SLOT_W-1:0]       slot_out,
    output logic [ptt_pkg::RUN_W-1:0]        run_count,
    output logic                             table_full,
    output logic                             last
);
    import ptt_pkg::*;

    logic             max_catch_up_reg;
    logic [CFG_W-1:0] max_catch_up_q_reg;
    logic [CFG_W-1:0] resync_periods_reg;
    logic             cfg_we;
    cfg_t             cfg;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_cmd;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_catch_up_reg   <= 1'b0;
            max_catch_up_q_reg <= CFG_RESET_VALUE;
            resync_periods_reg <= CFG_RESET_VALUE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_CATCH_UP:
                begin
                    max_catch_up_q_reg <= cfg_data;
                    max_catch_up_reg   <= 1'b1;
                end
                REG_RESYNC:
                begin
                    resync_periods_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.max_catch_up   = max_catch_up_q_reg;
    assign cfg.resync_periods = resync_periods_reg;

    // Front end: handshake, classification and command queue.
    ptt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .slot_index   (slot_index),
        .period_ticks (period_ticks),
        .now_ticks    (now_ticks),
        .busy         (busy),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    // Back end: slot table and pump sequencer.
    ptt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .done       (done),
        .slot_out   (slot_out),
        .run_count  (run_count),
        .table_full (table_full),
        .last       (last)
    );

    // Once written, the catch-up limit register holds the last written value.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_MAX_CATCH_UP) |=>
            (max_catch_up_q_reg == $past(cfg_data) && max_catch_up_reg))
        else $error("catch-up limit write lost");

    // A resync write lands in its own register and leaves the other alone.
    a_cfg_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_RESYNC) |=>
            (resync_periods_reg == $past(cfg_data) && $stable(max_catch_up_q_reg)))
        else $error("resync write corrupted configuration");

    // Without a configuration transfer both registers hold.
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> ($stable(resync_periods_reg) && $stable(max_catch_up_q_reg)))
        else $error("configuration changed without a write");

endmodule

// ===== hw/rtl/ptt_front.sv =====
// Front end: accepts input items, classifies them and queues commands.
module ptt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ptt_pkg::KIND_W-1:0]    kind,
    input  logic [ptt_pkg::SLOT_W-1:0]    slot_index,
    input  logic [ptt_pkg::PERIOD_W-1:0]  period_ticks,
    input  logic [ptt_pkg::NOW_W-1:0]     now_ticks,
    output logic                          busy,
    output logic                          q_valid,
    output ptt_pkg::cmd_t                 q_cmd,
    input  logic                          q_pop
);
    import ptt_pkg::*;

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    cmd_t              new_cmd;

    // Classify the incoming kind into a command code.
    always_comb
    begin
        new_cmd.idx    = slot_index;
        new_cmd.period = period_ticks;
        new_cmd.now    = now_ticks;
        unique case (kind)
            KIND_SETUP:  new_cmd.op = OP_SETUP;
            KIND_REMOVE: new_cmd.op = OP_REMOVE;
            KIND_PUMP:   new_cmd.op = OP_PUMP;
            default:     new_cmd.op = OP_NOP;
        endcase
    end

    // Handshake and queue status.
    assign busy    = (count_reg == QCNT_W'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_mem[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    // The back end never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("command popped from empty queue");

    // Occupancy never exceeds the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue occupancy out of range");

    // A transfer without a pop grows the queue by one entry.
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue occupancy did not follow a transfer");

endmodule

// ===== hw/rtl/ptt_back.sv =====
// Back end: slot table and the sequencer that executes queued commands.
module ptt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptt_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  ptt_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output logic                        done,
    output logic [ptt_pkg::SLOT_W-1:0]  slot_out,
    output logic [ptt_pkg::RUN_W-1:0]   run_count,
    output logic                        table_full,
    output logic                        last
);
    import ptt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SLOT  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Slot storage: payload memories and per-slot active flags.
    logic [PERIOD_W-1:0]    period_mem [TABLE_SLOTS];
    logic [DUE_W-1:0]       due_mem    [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] active_reg;
    logic [TABLE_SLOTS-1:0] active_next;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [IDX_W-1:0]    walk_reg;
    logic [IDX_W-1:0]    walk_next;
    logic [NOW_W-1:0]    now_reg;
    logic [NOW_W-1:0]    now_next;
    logic [DUE_W-1:0]    due_reg;
    logic [DUE_W-1:0]    due_next;
    logic [PERIOD_W-1:0] per_reg;
    logic [RUN_W-1:0]    runs_reg;
    logic [RUN_W-1:0]    runs_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic                pend_reg;
    logic                pend_next;
    logic [IDX_W-1:0]    pend_slot_reg;
    logic [IDX_W-1:0]    pend_slot_next;
    logic [RUN_W-1:0]    pend_runs_reg;
    logic [RUN_W-1:0]    pend_runs_next;

    logic                done_reg;
    logic                done_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [RUN_W-1:0]    run_reg;
    logic [RUN_W-1:0]    run_next;
    logic                full_reg;
    logic                full_next;
    logic                last_reg;
    logic                last_next;

    logic                setup_we;
    logic [IDX_W-1:0]    setup_idx;
    logic                due_we;
    logic [DUE_W-1:0]    due_final;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                walk_end;
    logic                due_reached;
    logic [DUE_W:0]      resync_limit;

    // Lowest free slot for a setup.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign walk_end     = (walk_reg == IDX_W'(TABLE_SLOTS - 1));
    assign due_reached  = ({{(DUE_W - NOW_W){1'b0}}, now_reg} >= due_reg);
    assign resync_limit = {1'b0, due_reg} + (DUE_W + 1)'(prod_reg);
    assign setup_idx    = free_idx;

    // Sequencer: one command at a time, a pump walks the slots in order.
    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        now_next       = now_reg;
        due_next       = due_reg;
        runs_next      = runs_reg;
        prod_next      = prod_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        pend_runs_next = pend_runs_reg;
        active_next    = active_reg;
        done_next      = 1'b0;
        slot_next      = slot_reg;
        run_next       = run_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        setup_we       = 1'b0;
        due_we         = 1'b0;
        due_final      = due_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    done_next = 1'b1;
                    slot_next = '0;
                    run_next  = '0;
                    full_next = 1'b0;
                    last_next = 1'b1;
                    unique case (q_cmd.op)
                        OP_SETUP:
                        begin
                            if (free_found)
                            begin
                                setup_we               = 1'b1;
                                active_next[setup_idx] = 1'b1;
                                slot_next              = SLOT_W'(setup_idx);
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            slot_next = q_cmd.idx;
                            if ({1'b0, q_cmd.idx} < (SLOT_W + 1)'(TABLE_SLOTS))
                            begin
                                active_next[q_cmd.idx[IDX_W-1:0]] = 1'b0;
                            end
                        end
                        OP_PUMP:
                        begin
                            done_next  = 1'b0;
                            now_next   = q_cmd.now;
                            walk_next  = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SLOT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SLOT:
            begin
                // The table read happens in the clocked block below.
                runs_next = '0;
                if (active_reg[walk_reg])
                begin
                    state_next = ST_RUN;
                end
                else if (walk_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    walk_next = walk_reg + 1'b1;
                end
            end

            ST_RUN:
            begin
                // One catch-up run per cycle.
                if (due_reached && (runs_reg < cfg.max_catch_up))
                begin
                    due_next  = due_reg + DUE_W'(per_reg);
                    runs_next = runs_reg + 1'b1;
                end
                else
                begin
                    prod_next  = cfg.resync_periods * per_reg;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                // Resync when still far behind, then write back next due.
                if ({{(DUE_W + 1 - NOW_W){1'b0}}, now_reg} >= resync_limit)
                begin
                    due_final = DUE_W'(now_reg) + DUE_W'(per_reg);
                end
                due_we = 1'b1;
                if (runs_reg != '0)
                begin
                    if (pend_reg)
                    begin
                        done_next = 1'b1;
                        slot_next = SLOT_W'(pend_slot_reg);
                        run_next  = pend_runs_reg;
                        full_next = 1'b0;
                        last_next = 1'b0;
                    end
                    pend_next      = 1'b1;
                    pend_slot_next = walk_reg;
                    pend_runs_next = runs_reg;
                end
                if (walk_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_SLOT;
                end
            end

            ST_DONE:
            begin
                // Final result of a pump: the held firing or an empty result.
                done_next  = 1'b1;
                slot_next  = pend_reg ? SLOT_W'(pend_slot_reg) : '0;
                run_next   = pend_reg ? pend_runs_reg : '0;
                full_next  = 1'b0;
                last_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        now_reg       <= now_next;
        runs_reg      <= runs_next;
        prod_reg      <= prod_next;
        pend_slot_reg <= pend_slot_next;
        pend_runs_reg <= pend_runs_next;
        slot_reg      <= slot_next;
        run_reg       <= run_next;
        full_reg      <= full_next;
        last_reg      <= last_next;
        if (state_reg == ST_SLOT)
        begin
            due_reg <= due_mem[walk_reg];
            per_reg <= period_mem[walk_reg];
        end
        else
        begin
            due_reg <= due_next;
        end
    end

    // Slot table writes.
    always_ff @(posedge clk)
    begin
        if (setup_we)
        begin
            period_mem[setup_idx] <= q_cmd.period;
            due_mem[setup_idx]    <= DUE_W'(q_cmd.now) + DUE_W'(q_cmd.period);
        end
        else if (due_we)
        begin
            due_mem[walk_reg] <= due_final;
        end
    end

    assign done       = done_reg;
    assign slot_out   = slot_reg;
    assign run_count  = run_reg;
    assign table_full = full_reg;
    assign last       = last_reg;

    // A full-table result carries no slot and no runs and closes its command.
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (slot_out == '0 && run_count == '0 && last))
        else $error("malformed table-full result");

    // Only results of firing slots may be followed by more results.
    a_zero_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && run_count == '0) |-> last)
        else $error("non-firing result not marked last");

    // No new command is taken while a pump is in progress.
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_pop)
        else $error("command popped during a pump");

endmodule

// ===== tb/periodic_task_timer_table_core_tb.sv =====
// Self-checking testbench for the periodic task timer table core.
module periodic_task_timer_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 400;
    localparam int GAP_PERCENT = 24;

    // What one entry of the stimulus feed asks the driver to do.
    typedef enum logic [1:0] {FEED_ITEM, FEED_CFG, FEED_DRAIN} feed_kind_t;

    typedef struct {
        feed_kind_t            what;
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     idx;
        logic [PERIOD_W-1:0]   period;
        logic [NOW_W-1:0]      now;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
    } feed_entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [RUN_W-1:0]  runs;
        logic              full;
        logic              last;
    } slot_result_t;

    // Clock, reset and block ports.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [KIND_W-1:0]     kind = '0;
    logic [SLOT_W-1:0]     slot_index = '0;
    logic [PERIOD_W-1:0]   period_ticks = '0;
    logic [NOW_W-1:0]      now_ticks = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  done;
    logic [SLOT_W-1:0]     slot_out;
    logic [RUN_W-1:0]      run_count;
    logic                  table_full;
    logic                  last;

    // Predicted table contents and limits.
    logic [PERIOD_W-1:0]   tbl_period [TABLE_SLOTS];
    logic [DUE_W-1:0]      tbl_due [TABLE_SLOTS];
    logic                  tbl_active [TABLE_SLOTS];
    logic [CFG_W-1:0]      lim_catch_up = CFG_RESET_VALUE;
    logic [CFG_W-1:0]      lim_resync = CFG_RESET_VALUE;

    feed_entry_t           command_feed[$];
    slot_result_t          awaited_results[$];
    logic [NOW_W-1:0]      tick_base = 32'd1000;

    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int n_setup = 0;
    int n_full = 0;
    int n_remove = 0;
    int n_pump = 0;
    int n_unused = 0;
    int n_fired = 0;
    int most_runs = 0;
    int cfg_writes = 0;
    int results_checked = 0;

    periodic_task_timer_table_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .slot_index   (slot_index),
        .period_ticks (period_ticks),
        .now_ticks    (now_ticks),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .slot_out     (slot_out),
        .run_count    (run_count),
        .table_full   (table_full),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Append one expected result behind the ones already waiting.
    function automatic void expect_result(input slot_result_t r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    // Append one entry to the end of the stimulus feed.
    function automatic void append_feed(input feed_entry_t e);
        command_feed.insert(command_feed.size(), e);
    endfunction

    // Apply one accepted command to the predicted table and queue its results.
    task automatic advance_timer_table(input logic [KIND_W-1:0] op_kind,
                                       input logic [SLOT_W-1:0] idx,
                                       input logic [PERIOD_W-1:0] period,
                                       input logic [NOW_W-1:0] now);
        slot_result_t     res;
        slot_result_t     held;
        bit               have_held;
        bit               claimed;
        logic [DUE_W-1:0] due;
        logic [63:0]      resync_edge;
        int               runs;
        res = '0;
        res.last = 1'b1;
        held = '0;
        have_held = 1'b0;
        claimed = 1'b0;
        case (op_kind)
            KIND_SETUP:
            begin
                n_setup++;
                for (int s = 0; s < TABLE_SLOTS && !claimed; s++)
                begin
                    if (!tbl_active[s])
                    begin
                        tbl_active[s] = 1'b1;
                        tbl_period[s] = period;
                        tbl_due[s] = DUE_W'(64'(now) + 64'(period));
                        res.slot = SLOT_W'(s);
                        claimed = 1'b1;
                    end
                end
                if (!claimed)
                begin
                    res.full = 1'b1;
                    n_full++;
                end
                expect_result(res);
            end
            KIND_REMOVE:
            begin
                n_remove++;
                if (int'(idx) < TABLE_SLOTS)
                    tbl_active[idx] = 1'b0;
                res.slot = idx;
                expect_result(res);
            end
            KIND_PUMP:
            begin
                n_pump++;
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    if (tbl_active[s])
                    begin
                        // Bounded catch-up, then resync when still far behind.
                        due = tbl_due[s];
                        runs = 0;
                        while (DUE_W'(now) >= due && runs < int'(lim_catch_up))
                        begin
                            due = due + DUE_W'(tbl_period[s]);
                            runs++;
                        end
                        resync_edge = 64'(due) + 64'(lim_resync) * 64'(tbl_period[s]);
                        if (64'(now) >= resync_edge)
                            due = DUE_W'(64'(now) + 64'(tbl_period[s]));
                        tbl_due[s] = due;
                        if (runs > 0)
                        begin
                            if (have_held)
                                expect_result(held);
                            held = '0;
                            held.slot = SLOT_W'(s);
                            held.runs = RUN_W'(runs);
                            have_held = 1'b1;
                            n_fired++;
                            if (runs > most_runs)
                                most_runs = runs;
                        end
                    end
                end
                // The final firing slot closes the pump; otherwise one empty result.
                if (have_held)
                begin
                    held.last = 1'b1;
                    expect_result(held);
                end
                else
                    expect_result(res);
            end
            default:
            begin
                n_unused++;
                expect_result(res);
            end
        endcase
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        if (idx == REG_MAX_CATCH_UP)
            lim_catch_up = val;
        else if (idx == REG_RESYNC)
            lim_resync = val;
        cfg_writes++;
    endtask

    task automatic queue_item(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] idx,
                              input logic [PERIOD_W-1:0] period, input logic [NOW_W-1:0] now);
        feed_entry_t e;
        e.what = FEED_ITEM;
        e.kind = k;
        e.idx = idx;
        e.period = period;
        e.now = now;
        e.reg_idx = '0;
        e.reg_val = '0;
        append_feed(e);
    endtask

    task automatic queue_limits(input logic [CFG_W-1:0] catch_up, input logic [CFG_W-1:0] resync);
        feed_entry_t e;
        e.what = FEED_CFG;
        e.kind = '0;
        e.idx = '0;
        e.period = '0;
        e.now = '0;
        e.reg_idx = REG_MAX_CATCH_UP;
        e.reg_val = catch_up;
        append_feed(e);
        e.reg_idx = REG_RESYNC;
        e.reg_val = resync;
        append_feed(e);
    endtask

    task automatic queue_drain();
        feed_entry_t e;
        e.what = FEED_DRAIN;
        e.kind = '0;
        e.idx = '0;
        e.period = '0;
        e.now = '0;
        e.reg_idx = '0;
        e.reg_val = '0;
        append_feed(e);
    endtask

    // Mostly setups, removes and pumps on a rising tick; some noise mixed in.
    task automatic queue_random_items(input int count);
        int                  pick;
        logic [PERIOD_W-1:0] per;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                case ($urandom_range(0, 9))
                    0: per = '0;
                    1: per = PERIOD_W'($urandom);
                    default: per = PERIOD_W'($urandom_range(1, 60));
                endcase
                queue_item(KIND_SETUP, SLOT_W'($urandom), per, tick_base);
            end
            else if (pick < 45)
                queue_item(KIND_REMOVE, SLOT_W'($urandom), PERIOD_W'($urandom), NOW_W'($urandom));
            else if (pick < 90)
            begin
                if ($urandom_range(0, 39) == 0)
                    tick_base = tick_base + NOW_W'($urandom_range(0, 1 << 20));
                else
                    tick_base = tick_base + NOW_W'($urandom_range(0, 300));
                queue_item(KIND_PUMP, SLOT_W'($urandom), PERIOD_W'($urandom), tick_base);
            end
            else if (pick < 94)
                queue_item(KIND_PUMP, SLOT_W'($urandom), PERIOD_W'($urandom), NOW_W'($urandom));
            else if (pick < 97)
                queue_item(KIND_UNUSED, SLOT_W'($urandom), PERIOD_W'($urandom), NOW_W'($urandom));
            else
                queue_item(KIND_SETUP, SLOT_W'($urandom), PERIOD_W'($urandom), NOW_W'($urandom));
        end
    endtask

    // Driver: one feed entry at a time; start holds until its transfer.
    always @(posedge clk)
    begin : drive_commands
        feed_entry_t head;
        logic        hold_start;
        logic        hold_cfg;
        logic        take_head;
        logic        gap_free;
        hold_start = start;
        hold_cfg = cfg_valid;
        take_head = 1'b0;
        gap_free = (items_sent >= 150 && items_sent < 230);
        if (rst_n)
        begin
            if (start && !busy)
            begin
                advance_timer_table(kind, slot_index, period_ticks, now_ticks);
                items_sent++;
                hold_start = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_limit(cfg_index, cfg_data);
                hold_cfg = 1'b0;
            end
            // Register writes and drain points wait until every result has come.
            if (!hold_start && !hold_cfg && command_feed.size() != 0)
            begin
                head = command_feed[0];
                if (head.what == FEED_ITEM)
                    take_head = gap_free || ($urandom_range(0, 99) >= GAP_PERCENT);
                else
                    take_head = (awaited_results.size() == 0);
            end
            if (take_head)
            begin
                void'(command_feed.pop_front());
                if (head.what == FEED_ITEM)
                begin
                    hold_start = 1'b1;
                    kind <= head.kind;
                    slot_index <= head.idx;
                    period_ticks <= head.period;
                    now_ticks <= head.now;
                end
                else if (head.what == FEED_CFG)
                begin
                    hold_cfg = 1'b1;
                    cfg_index <= head.reg_idx;
                    cfg_data <= head.reg_val;
                end
            end
            start <= hold_start;
            cfg_valid <= hold_cfg;
        end
    end

    // Monitor: results are sampled mid-cycle, each against the oldest expectation.
    always @(negedge clk)
    begin : check_results
        slot_result_t want;
        if (rst_n)
        begin
            if ($isunknown(done))
            begin
                $error("done is unknown");
                error_count++;
            end
            else if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: slot_out %0d run_count %0d", slot_out, run_count);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (slot_out !== want.slot)
                    begin
                        $error("slot_out: expected %0d, got %0d", want.slot, slot_out);
                        error_count++;
                    end
                    if (run_count !== want.runs)
                    begin
                        $error("run_count: expected %0d, got %0d", want.runs, run_count);
                        error_count++;
                    end
                    if (table_full !== want.full)
                    begin
                        $error("table_full: expected %0d, got %0d", want.full, table_full);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("periodic_task_timer_table_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            tbl_period[s] = '0;
            tbl_due[s] = '0;
            tbl_active[s] = 1'b0;
        end

        // Directed part at reset limits: empty pump, unused kind, idle remove.
        queue_item(KIND_PUMP, '0, '0, '0);
        queue_item(KIND_UNUSED, 4'hF, 20'hFFFFF, 32'hFFFFFFFF);
        queue_item(KIND_REMOVE, 4'hF, '0, '0);
        // Fill the table: largest period and tick, a zero period, then small ones.
        queue_item(KIND_SETUP, '0, 20'hFFFFF, 32'hFFFFFFFF);
        queue_item(KIND_SETUP, '0, 20'd0, 32'd100);
        queue_item(KIND_SETUP, '0, 20'd10, 32'd100);
        queue_item(KIND_SETUP, '0, 20'd3, 32'd100);
        for (int s = 4; s < TABLE_SLOTS; s++)
            queue_item(KIND_SETUP, '0, PERIOD_W'($urandom_range(1, 40)), 32'd100);
        // Setup on a full table, then a pump with catch-up and resync.
        queue_item(KIND_SETUP, '0, 20'd5, 32'd100);
        queue_item(KIND_PUMP, '0, '0, 32'd200);
        // Free and reclaim the lowest slot, then fire every slot at the top tick.
        queue_item(KIND_REMOVE, 4'd0, '0, '0);
        queue_item(KIND_SETUP, '0, 20'd1, 32'd300);
        queue_item(KIND_PUMP, '0, '0, 32'hFFFFFFFF);

        // Clear the table so the random part starts near tick zero.
        for (int s = 0; s < TABLE_SLOTS; s++)
            queue_item(KIND_REMOVE, SLOT_W'(s), PERIOD_W'($urandom), NOW_W'($urandom));

        // Random phases over several register settings, extremes among them.
        queue_limits(4'd15, 4'd15);
        queue_random_items(60);
        queue_limits(4'd1, 4'd1);
        queue_random_items(30);
        queue_drain();
        queue_random_items(30);
        queue_limits(4'd0, 4'd0);
        queue_random_items(40);
        queue_limits(4'd15, 4'd0);
        queue_random_items(55);
        queue_limits(4'd0, 4'd15);
        queue_random_items(35);
        queue_limits(CFG_W'($urandom_range(1, 15)), CFG_W'($urandom_range(1, 15)));
        queue_random_items(60);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the feed and every expected result, then a quiet tail.
        while (command_feed.size() != 0 || start || cfg_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d setups (%0d on a full table), %0d removes, %0d pumps, %0d unused kinds.",
                 n_setup, n_full, n_remove, n_pump, n_unused);
        $display("Checked %0d results with %0d slot firings (up to %0d runs), %0d register writes.",
                 results_checked, n_fired, most_runs, cfg_writes);
        if (error_count == 0)
            $display("periodic_task_timer_table_core_tb: done, clean");
        else
            $display("periodic_task_timer_table_core_tb: done, errors");
        $finish;
    end

endmodule
